>>> src/at_can_frame_deframer_core_assert.svh
// Assertion macros for the serial CAN frame deframer.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef AT_CAN_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define AT_CAN_FRAME_DEFRAMER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ATCD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be true outside reset.
`define ATCD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ATCD_ASSERT(lbl, clk, rst_n, prop, msg)
`define ATCD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> src/atcd_pkg.sv
// Shared constants, types and helpers for the serial CAN frame deframer.
// No dependencies; used by the interfaces and the core.
`timescale 1ns / 1ps

package atcd_pkg;

	localparam int MAX_PAYLOAD = 8;
	localparam int HDR_LEN     = 7;
	localparam int TAIL_LEN    = 2;
	localparam int WIN_DEPTH   = 17;
	localparam int WIN_AW      = $clog2(WIN_DEPTH + 1);
	localparam int ID_W        = 29;
	localparam int LEN_W       = 4;
	localparam int PAYLOAD_W   = 64;

	localparam logic [7:0] CH_A  = 8'h41;
	localparam logic [7:0] CH_T  = 8'h54;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	typedef logic [7:0]           byte_t;
	typedef logic [ID_W-1:0]      can_id_t;
	typedef logic [LEN_W-1:0]     len_t;
	typedef logic [PAYLOAD_W-1:0] payload_t;
	typedef logic [WIN_AW-1:0]    win_idx_t;

	// Add two window positions modulo the window depth (their sum below twice the depth).
	function automatic win_idx_t wrap_add(input win_idx_t a, input win_idx_t b);
		logic [WIN_AW:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= (WIN_AW+1)'(WIN_DEPTH)) begin
			sum = sum - (WIN_AW+1)'(WIN_DEPTH);
		end
		return sum[WIN_AW-1:0];
	endfunction

endpackage

>>> src/atcd_rx_if.sv
// Byte channel from the serial receiver: valid/ready plus one received byte.
// Depends on atcd_pkg.
`timescale 1ns / 1ps

interface atcd_rx_if;
	import atcd_pkg::*;

	logic  valid;
	logic  ready;
	byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

>>> src/atcd_frame_if.sv
// Decoded frame channel: valid/ready plus identifier, length and payload.
// Depends on atcd_pkg.
`timescale 1ns / 1ps

interface atcd_frame_if;
	import atcd_pkg::*;

	logic     valid;
	logic     ready;
	can_id_t  can_id;
	len_t     payload_length;
	payload_t payload;

	modport source (output valid, output can_id, output payload_length, output payload,
		input ready);
	modport sink (input valid, input can_id, input payload_length, input payload,
		output ready);
endinterface

>>> src/at_can_frame_deframer_core.sv
// Serial CAN frame deframer: byte window in a circular buffer and a scan sequencer.
// Throughput: one byte per scan; a scan reads one window byte at a time through one
// registered read port, addressed by a modulo-17 adder; a scan ends after the frame or wait.
// Sequence from the accepting edge: S_START, then S_ISSUE and S_CHECK per byte checked (9 + length
// bytes for a valid frame), then S_EMIT; each resync drop returns to S_START to restart the check.
// Reset: asynchronous, clears count, head pointer, sequencer and output valid; no clearing pass.
`timescale 1ns / 1ps

module at_can_frame_deframer_core (
	input logic          clk,
	input logic          arst_n,
	atcd_rx_if.sink      rx,
	atcd_frame_if.source frame
);
	import atcd_pkg::*;
	`include "at_can_frame_deframer_core_assert.svh"

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_ISSUE,
		S_CHECK,
		S_EMIT
	} state_t;

	typedef enum logic [2:0] {
		P_A,
		P_T,
		P_LEN,
		P_CR,
		P_LF,
		P_ID,
		P_PL
	} phase_t;

	state_t   state_q;
	phase_t   phase_q;
	win_idx_t head_q;
	win_idx_t count_q;
	win_idx_t ofs_q;
	win_idx_t total_q;
	len_t     len_q;
	byte_t    rd_q;
	logic [31:0] id_q;
	payload_t pl_q;

	byte_t    win_mem [WIN_DEPTH];

	logic     out_valid_q;
	can_id_t  out_id_q;
	len_t     out_len_q;
	payload_t out_pl_q;

	logic     rx_accept;
	logic     out_load;
	logic [8:0] total_w;
	win_idx_t rd_addr;
	win_idx_t wr_addr;
	logic [2:0] pl_idx;
	win_idx_t ofs_pl;

	assign rx.ready  = (state_q == S_IDLE);
	assign rx_accept = rx.valid && rx.ready;
	assign out_load  = (state_q == S_EMIT) && (!out_valid_q || frame.ready);

	// Position adders: read and write addresses into the circular window
	assign rd_addr = wrap_add(head_q, ofs_q);
	assign wr_addr = wrap_add(head_q, count_q);

	// Frame size for the length byte under check
	assign total_w = 9'(HDR_LEN + TAIL_LEN) + {1'b0, rd_q};
	assign ofs_pl  = ofs_q - win_idx_t'(HDR_LEN);
	assign pl_idx  = ofs_pl[2:0];

	// Window storage: write on arrival, registered read for the scan
	always_ff @(posedge clk) begin
		if (rx_accept) begin
			win_mem[wr_addr] <= rx.rx_byte;
		end
		if (state_q == S_ISSUE) begin
			rd_q <= win_mem[rd_addr];
		end
	end

	// Scan sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= P_A;
			head_q      <= '0;
			count_q     <= '0;
			ofs_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Drop the delivered result unless a new one loads
			if (frame.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (rx_accept) begin
						if (count_q == win_idx_t'(WIN_DEPTH)) begin
							head_q <= wrap_add(head_q, win_idx_t'(1));
						end else begin
							count_q <= count_q + win_idx_t'(1);
						end
						state_q <= S_START;
					end
				end
				S_START: begin
					if (count_q >= win_idx_t'(HDR_LEN + TAIL_LEN)) begin
						ofs_q   <= '0;
						phase_q <= P_A;
						state_q <= S_ISSUE;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_ISSUE: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					case (phase_q)
						P_A: begin
							if (rd_q == CH_A) begin
								ofs_q   <= win_idx_t'(1);
								phase_q <= P_T;
								state_q <= S_ISSUE;
							end else begin
								head_q  <= wrap_add(head_q, win_idx_t'(1));
								count_q <= count_q - win_idx_t'(1);
								state_q <= S_START;
							end
						end
						P_T: begin
							if (rd_q == CH_T) begin
								ofs_q   <= win_idx_t'(6);
								phase_q <= P_LEN;
								state_q <= S_ISSUE;
							end else begin
								head_q  <= wrap_add(head_q, win_idx_t'(1));
								count_q <= count_q - win_idx_t'(1);
								state_q <= S_START;
							end
						end
						P_LEN: begin
							pl_q <= '0;
							if ((rd_q > byte_t'(MAX_PAYLOAD)) ||
								(total_w > 9'(WIN_DEPTH))) begin
								head_q  <= wrap_add(head_q, win_idx_t'(1));
								count_q <= count_q - win_idx_t'(1);
								state_q <= S_START;
							end else if ({4'b0, count_q} < total_w) begin
								// Hold the bytes until the frame completes
								state_q <= S_IDLE;
							end else begin
								len_q   <= rd_q[LEN_W-1:0];
								total_q <= total_w[WIN_AW-1:0];
								ofs_q   <= total_w[WIN_AW-1:0] - win_idx_t'(TAIL_LEN);
								phase_q <= P_CR;
								state_q <= S_ISSUE;
							end
						end
						P_CR: begin
							if (rd_q == CH_CR) begin
								ofs_q   <= total_q - win_idx_t'(1);
								phase_q <= P_LF;
								state_q <= S_ISSUE;
							end else begin
								head_q  <= wrap_add(head_q, win_idx_t'(1));
								count_q <= count_q - win_idx_t'(1);
								state_q <= S_START;
							end
						end
						P_LF: begin
							if (rd_q == CH_LF) begin
								ofs_q   <= win_idx_t'(2);
								phase_q <= P_ID;
								state_q <= S_ISSUE;
							end else begin
								head_q  <= wrap_add(head_q, win_idx_t'(1));
								count_q <= count_q - win_idx_t'(1);
								state_q <= S_START;
							end
						end
						P_ID: begin
							id_q <= {id_q[23:0], rd_q};
							if (ofs_q == win_idx_t'(HDR_LEN - 2)) begin
								if (len_q == '0) begin
									state_q <= S_EMIT;
								end else begin
									ofs_q   <= win_idx_t'(HDR_LEN);
									phase_q <= P_PL;
									state_q <= S_ISSUE;
								end
							end else begin
								ofs_q   <= ofs_q + win_idx_t'(1);
								state_q <= S_ISSUE;
							end
						end
						P_PL: begin
							pl_q[pl_idx*8 +: 8] <= rd_q;
							if (ofs_pl == win_idx_t'(len_q) - win_idx_t'(1)) begin
								state_q <= S_EMIT;
							end else begin
								ofs_q   <= ofs_q + win_idx_t'(1);
								state_q <= S_ISSUE;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_EMIT: begin
					// Wait for the output register, then remove the frame bytes
					if (out_load) begin
						out_valid_q <= 1'b1;
						out_id_q    <= id_q[31:3];
						out_len_q   <= len_q;
						out_pl_q    <= pl_q;
						head_q      <= wrap_add(head_q, total_q);
						count_q     <= count_q - total_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign frame.valid          = out_valid_q;
	assign frame.can_id         = out_id_q;
	assign frame.payload_length = out_len_q;
	assign frame.payload        = out_pl_q;

	`ATCD_ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > win_idx_t'(WIN_DEPTH), "window count above depth")
	`ATCD_ASSERT_NEVER(a_read_held, clk, arst_n, (state_q == S_ISSUE) && (ofs_q >= count_q), "scan read beyond held bytes")
	`ATCD_ASSERT(a_load_len, clk, arst_n, out_load |-> (len_q <= len_t'(MAX_PAYLOAD)) && (total_q <= count_q), "emitted frame malformed")
	`ATCD_ASSERT(a_accept_start, clk, arst_n, rx_accept |=> (state_q == S_START), "arrival did not start a scan")

endmodule
